[hdl/assert_macros.svh]
// Assertion macros shared by the escape decoder modules.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ESD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/esd_pkg.sv]
// Shared types, character constants and helpers for the escape decoder.
// Used by esd_core, esd_outbuf and escape_sequence_decoder_unit.
package esd_pkg;

    localparam logic [2:0] PH_PLAIN     = 3'd0;
    localparam logic [2:0] PH_BACKSLASH = 3'd1;
    localparam logic [2:0] PH_OCTAL     = 3'd2;
    localparam logic [2:0] PH_HEX0      = 3'd3;
    localparam logic [2:0] PH_HEX1      = 3'd4;

    localparam logic [2:0] C_MAX_RES = 3'd4;

    localparam logic [7:0] C_BSL   = 8'h5C;
    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_X     = 8'h78;
    localparam logic [7:0] C_N     = 8'h6E;
    localparam logic [7:0] C_R     = 8'h72;
    localparam logic [7:0] C_T     = 8'h74;
    localparam logic [7:0] C_B     = 8'h62;
    localparam logic [7:0] C_F     = 8'h66;
    localparam logic [7:0] C_V     = 8'h76;

    localparam logic [7:0] C_LF  = 8'd10;
    localparam logic [7:0] C_CR  = 8'd13;
    localparam logic [7:0] C_TAB = 8'd9;
    localparam logic [7:0] C_BS  = 8'd8;
    localparam logic [7:0] C_FF  = 8'd12;
    localparam logic [7:0] C_VT  = 8'd11;

    // Up to four decoded bytes produced by one request.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      cnt;
    } t_res;

    // Load strobe from the decoder into the result buffer.
    typedef struct packed {
        logic vld;
        t_res res;
    } t_ld;

    function automatic t_res f_push(t_res r, logic [7:0] b);
        t_res o;
        o = r;
        if (r.cnt < C_MAX_RES) begin
            o.data[r.cnt[1:0]] = b;
            o.cnt = r.cnt + 3'd1;
        end
        return o;
    endfunction

endpackage

[hdl/escape_sequence_decoder_unit.sv]
// Top level of the string literal escape decoder.
// Depends on esd_pkg, esd_core and esd_outbuf.

// Decodes C string literal bytes, one request per input byte, and returns the
// decoded bytes on the output stream, with tlast on the final byte caused by each
// request (a request may cause none, one or up to four). A request passes an input
// register, is decoded combinationally into a four-byte result buffer, and its
// bytes leave one per cycle while the output is ready. The input takes one request
// per cycle while each causes at most one byte and the output is ready; a request
// that causes more keeps the result buffer until its last byte leaves, and the next
// request waits in the input register. strip_quotes is written through i_cfg_wr_en
// and resets to 1; change it only while the block is idle.
module escape_sequence_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,    // strip_quotes
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tuser,   // is_first
    input  logic       i_s_axis_tlast,   // is_last
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast    // run_end
);

    logic         r_strip;
    logic         w_free;
    esd_pkg::t_ld w_ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_strip <= i_cfg_wr_data;
        end
    end

    esd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_strip    (r_strip),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_byte   (i_s_axis_tdata),
        .i_s_first  (i_s_axis_tuser),
        .i_s_last   (i_s_axis_tlast),
        .i_free     (w_free),
        .o_ld       (w_ld)
    );

    esd_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ld       (w_ld),
        .o_free     (w_free),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast)
    );

endmodule

[hdl/esd_core.sv]
// Input register, escape state and single-pass decode of one request.
// Depends on esd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module esd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_strip,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_byte,
    input  logic             i_s_first,
    input  logic             i_s_last,
    input  logic             i_free,
    output esd_pkg::t_ld     o_ld
);

    typedef struct packed {
        logic [2:0]    phase;
        logic [5:0]    oval;
        logic [1:0]    odig;
        logic [7:0]    held;
        esd_pkg::t_res res;
    } t_dec;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_first;
    logic       r_in_last;
    logic [2:0] r_phase, n_phase;
    logic [5:0] r_oval, n_oval;
    logic [1:0] r_odig, n_odig;
    logic [7:0] r_held, n_held;
    logic       w_move;
    logic       w_drop;
    t_dec       w_dec;

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] f_hex(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    function automatic t_dec f_plain(t_dec s, logic [7:0] c);
        t_dec o;
        o = s;
        o.phase = esd_pkg::PH_PLAIN;
        if (c == esd_pkg::C_BSL) begin
            o.phase = esd_pkg::PH_BACKSLASH;
        end else begin
            o.res = esd_pkg::f_push(o.res, c);
        end
        return o;
    endfunction

    function automatic t_dec f_esc(t_dec s, logic [7:0] c);
        t_dec o;
        o = s;
        o.phase = esd_pkg::PH_PLAIN;
        if (c == esd_pkg::C_N) begin
            o.res = esd_pkg::f_push(o.res, esd_pkg::C_LF);
        end else if (c == esd_pkg::C_R) begin
            o.res = esd_pkg::f_push(o.res, esd_pkg::C_CR);
        end else if (c == esd_pkg::C_T) begin
            o.res = esd_pkg::f_push(o.res, esd_pkg::C_TAB);
        end else if (c == esd_pkg::C_B) begin
            o.res = esd_pkg::f_push(o.res, esd_pkg::C_BS);
        end else if (c == esd_pkg::C_F) begin
            o.res = esd_pkg::f_push(o.res, esd_pkg::C_FF);
        end else if (c == esd_pkg::C_V) begin
            o.res = esd_pkg::f_push(o.res, esd_pkg::C_VT);
        end else if (c == esd_pkg::C_BSL || c == esd_pkg::C_QUOTE) begin
            o.res = esd_pkg::f_push(o.res, c);
        end else if (c == esd_pkg::C_ZERO) begin
            o.phase = esd_pkg::PH_OCTAL;
            o.oval  = 6'd0;
            o.odig  = 2'd1;
        end else if (c == esd_pkg::C_X) begin
            o.phase = esd_pkg::PH_HEX0;
        end else begin
            o.res = esd_pkg::f_push(o.res, esd_pkg::C_BSL);
            o.res = esd_pkg::f_push(o.res, c);
        end
        return o;
    endfunction

    function automatic t_dec f_feed(t_dec s, logic [7:0] c);
        t_dec       o;
        logic [4:0] hi;
        logic [4:0] lo;
        o  = s;
        hi = f_hex(s.held);
        lo = f_hex(c);
        unique case (s.phase)
            esd_pkg::PH_BACKSLASH: begin
                o = f_esc(o, c);
            end
            esd_pkg::PH_OCTAL: begin
                if (c[7:3] == esd_pkg::C_ZERO[7:3]) begin
                    o.oval = {s.oval[2:0], c[2:0]};
                    o.odig = s.odig + 2'd1;
                    if (o.odig == 2'd3) begin
                        o.res   = esd_pkg::f_push(o.res, {2'b00, o.oval});
                        o.phase = esd_pkg::PH_PLAIN;
                    end
                end else begin
                    o.res = esd_pkg::f_push(o.res, {2'b00, s.oval});
                    o = f_plain(o, c);
                end
            end
            esd_pkg::PH_HEX0: begin
                o.held  = c;
                o.phase = esd_pkg::PH_HEX1;
            end
            esd_pkg::PH_HEX1: begin
                if (hi[4] && lo[4]) begin
                    o.res   = esd_pkg::f_push(o.res, {hi[3:0], lo[3:0]});
                    o.phase = esd_pkg::PH_PLAIN;
                end else begin
                    // Bad hex: give backslash and x, then replay both bytes as plain input.
                    o.res = esd_pkg::f_push(o.res, esd_pkg::C_BSL);
                    o.res = esd_pkg::f_push(o.res, esd_pkg::C_X);
                    o = f_plain(o, s.held);
                    if (o.phase == esd_pkg::PH_BACKSLASH) begin
                        o = f_esc(o, c);
                    end else begin
                        o = f_plain(o, c);
                    end
                end
            end
            default: begin
                o = f_plain(o, c);
            end
        endcase
        return o;
    endfunction

    function automatic t_dec f_flush(t_dec s);
        t_dec o;
        o = s;
        unique case (s.phase)
            esd_pkg::PH_BACKSLASH: begin
                o.res = esd_pkg::f_push(o.res, esd_pkg::C_BSL);
            end
            esd_pkg::PH_OCTAL: begin
                o.res = esd_pkg::f_push(o.res, {2'b00, s.oval});
            end
            esd_pkg::PH_HEX0: begin
                o.res = esd_pkg::f_push(o.res, esd_pkg::C_BSL);
                o.res = esd_pkg::f_push(o.res, esd_pkg::C_X);
            end
            esd_pkg::PH_HEX1: begin
                // A held backslash would start an escape that is flushed at once.
                o.res = esd_pkg::f_push(o.res, esd_pkg::C_BSL);
                o.res = esd_pkg::f_push(o.res, esd_pkg::C_X);
                o.res = esd_pkg::f_push(o.res, s.held);
            end
            default: begin
            end
        endcase
        o.phase = esd_pkg::PH_PLAIN;
        o.oval  = 6'd0;
        o.odig  = 2'd0;
        o.held  = 8'd0;
        return o;
    endfunction

    assign w_move     = r_in_vld && i_free;
    assign o_s_tready = !r_in_vld || w_move;
    assign w_drop     = i_strip && (r_in_first != r_in_last);

    always_comb begin
        w_dec.phase = r_phase;
        w_dec.oval  = r_oval;
        w_dec.odig  = r_odig;
        w_dec.held  = r_held;
        w_dec.res   = '0;
        if (r_in_first) begin
            w_dec.phase = esd_pkg::PH_PLAIN;
            w_dec.oval  = 6'd0;
            w_dec.odig  = 2'd0;
            w_dec.held  = 8'd0;
        end
        if (!w_drop) begin
            w_dec = f_feed(w_dec, r_in_byte);
        end
        if (r_in_last) begin
            w_dec = f_flush(w_dec);
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_oval  = r_oval;
        n_odig  = r_odig;
        n_held  = r_held;
        if (w_move) begin
            n_phase = w_dec.phase;
            n_oval  = w_dec.oval;
            n_odig  = w_dec.odig;
            n_held  = w_dec.held;
        end
    end

    assign o_ld.vld = w_move;
    assign o_ld.res = w_dec.res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_phase  <= esd_pkg::PH_PLAIN;
            r_oval   <= 6'd0;
            r_odig   <= 2'd0;
            r_held   <= 8'd0;
        end else begin
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            r_phase <= n_phase;
            r_oval  <= n_oval;
            r_odig  <= n_odig;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_byte;
            r_in_first <= i_s_first;
            r_in_last  <= i_s_last;
        end
    end

    `ESD_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_move && r_in_last,
        r_phase == esd_pkg::PH_PLAIN && r_odig == 2'd0 && r_held == 8'd0,
        "escape state not cleared after last byte")
    `ESD_ASSERT_IMPL(a_octal_digits, i_clk, i_rst_n, r_phase == esd_pkg::PH_OCTAL,
        r_odig == 2'd1 || r_odig == 2'd2, "octal digit count out of range")
    `ESD_ASSERT_IMPL(a_hex_order, i_clk, i_rst_n,
        r_phase == esd_pkg::PH_HEX1 && !$stable(r_phase),
        $past(r_phase) == esd_pkg::PH_HEX0, "second hex byte reached without first")

endmodule

[hdl/esd_outbuf.sv]
// Result buffer for one request's bytes; sends one per cycle when tready is high.
// Depends on esd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module esd_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  esd_pkg::t_ld     i_ld,
    output logic             o_free,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,
    output logic             o_m_tlast
);

    logic [3:0][7:0] r_data;
    logic [2:0]      r_left, n_left;
    logic [1:0]      r_pos, n_pos;
    logic            w_take;

    assign o_m_tvalid = (r_left != 3'd0);
    assign w_take     = o_m_tvalid && i_m_tready;
    // Free when empty or when the final byte leaves in this cycle.
    assign o_free     = (r_left == 3'd0) || (r_left == 3'd1 && i_m_tready);
    assign o_m_tdata  = r_data[r_pos];
    assign o_m_tlast  = (r_left == 3'd1);

    always_comb begin
        n_left = r_left;
        n_pos  = r_pos;
        if (i_ld.vld) begin
            n_left = i_ld.res.cnt;
            n_pos  = 2'd0;
        end else if (w_take) begin
            n_left = r_left - 3'd1;
            n_pos  = r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_pos  <= 2'd0;
        end else begin
            r_left <= n_left;
            r_pos  <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.vld) begin
            r_data <= i_ld.res.data;
        end
    end

    `ESD_ASSERT_NEXT(a_drain_ends, i_clk, i_rst_n,
        o_m_tvalid && i_m_tready && r_left == 3'd1 && !i_ld.vld,
        !o_m_tvalid, "result stream continued past its last byte")
    `ESD_ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, i_ld.vld,
        r_left == 3'd0 || (r_left == 3'd1 && w_take), "load over pending results")

endmodule

[sim/escape_sequence_decoder_unit_checker.sv]
// Checker for the escape decoder: predicts the decoded bytes of every accepted request
// and compares them with the output stream. Depends on esd_pkg for character constants.
module escape_sequence_decoder_unit_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tuser,
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,
    input  logic       i_m_tlast,
    output int         o_mismatches,
    output int         o_outstanding,
    output int         o_checked
);

    localparam logic [7:0] CH_SEVEN = 8'h37;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
    } t_dec_out;

    t_dec_out   expected_bytes[$];
    t_dec_out   oldest;
    logic [7:0] step_bytes[$];

    logic       strip_en;
    logic [2:0] dec_phase;
    logic [5:0] oct_acc;
    logic [1:0] oct_cnt;
    logic [7:0] hex_held;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        o_checked     = 0;
    end

    function automatic int hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    // A request never produces more than four bytes; extra ones are lost.
    task automatic push_decoded(input logic [7:0] b);
        if (step_bytes.size() < int'(esd_pkg::C_MAX_RES)) step_bytes.push_back(b);
    endtask

    // Predicts the bytes caused by one request and queues them as expected output.
    task automatic decode_request(input logic [7:0] c, input logic first, input logic last);
        logic [7:0] work[$];
        logic [7:0] b;
        int         hi;
        int         lo;
        step_bytes.delete();
        if (first) begin
            dec_phase = esd_pkg::PH_PLAIN;
            oct_acc   = '0;
            oct_cnt   = '0;
            hex_held  = '0;
        end
        if (!(strip_en && (first != last))) work.push_back(c);
        // Bytes that end an escape early are pushed back and decoded again as plain input.
        while (work.size() > 0) begin
            b = work.pop_front();
            case (dec_phase)
                esd_pkg::PH_BACKSLASH: begin
                    dec_phase = esd_pkg::PH_PLAIN;
                    case (b)
                        esd_pkg::C_N:     push_decoded(esd_pkg::C_LF);
                        esd_pkg::C_R:     push_decoded(esd_pkg::C_CR);
                        esd_pkg::C_T:     push_decoded(esd_pkg::C_TAB);
                        esd_pkg::C_B:     push_decoded(esd_pkg::C_BS);
                        esd_pkg::C_F:     push_decoded(esd_pkg::C_FF);
                        esd_pkg::C_V:     push_decoded(esd_pkg::C_VT);
                        esd_pkg::C_BSL:   push_decoded(esd_pkg::C_BSL);
                        esd_pkg::C_QUOTE: push_decoded(esd_pkg::C_QUOTE);
                        esd_pkg::C_ZERO: begin
                            dec_phase = esd_pkg::PH_OCTAL;
                            oct_acc   = '0;
                            oct_cnt   = 2'd1;
                        end
                        esd_pkg::C_X:     dec_phase = esd_pkg::PH_HEX0;
                        default: begin
                            push_decoded(esd_pkg::C_BSL);
                            push_decoded(b);
                        end
                    endcase
                end
                esd_pkg::PH_OCTAL: begin
                    if (b >= esd_pkg::C_ZERO && b <= CH_SEVEN) begin
                        oct_acc = {oct_acc[2:0], b[2:0]};
                        oct_cnt = oct_cnt + 2'd1;
                        if (oct_cnt == 2'd3) begin
                            push_decoded({2'b00, oct_acc});
                            dec_phase = esd_pkg::PH_PLAIN;
                        end
                    end else begin
                        push_decoded({2'b00, oct_acc});
                        dec_phase = esd_pkg::PH_PLAIN;
                        work.push_front(b);
                    end
                end
                esd_pkg::PH_HEX0: begin
                    hex_held  = b;
                    dec_phase = esd_pkg::PH_HEX1;
                end
                esd_pkg::PH_HEX1: begin
                    hi        = hex_val(hex_held);
                    lo        = hex_val(b);
                    dec_phase = esd_pkg::PH_PLAIN;
                    if (hi >= 0 && lo >= 0) begin
                        push_decoded(8'(hi * 16 + lo));
                    end else begin
                        push_decoded(esd_pkg::C_BSL);
                        push_decoded(esd_pkg::C_X);
                        work.push_front(b);
                        work.push_front(hex_held);
                    end
                end
                default: begin
                    dec_phase = esd_pkg::PH_PLAIN;
                    if (b == esd_pkg::C_BSL) dec_phase = esd_pkg::PH_BACKSLASH;
                    else push_decoded(b);
                end
            endcase
        end
        if (last) begin
            // A held byte after \x comes out as itself, even when it is a backslash.
            case (dec_phase)
                esd_pkg::PH_BACKSLASH: push_decoded(esd_pkg::C_BSL);
                esd_pkg::PH_OCTAL:     push_decoded({2'b00, oct_acc});
                esd_pkg::PH_HEX0: begin
                    push_decoded(esd_pkg::C_BSL);
                    push_decoded(esd_pkg::C_X);
                end
                esd_pkg::PH_HEX1: begin
                    push_decoded(esd_pkg::C_BSL);
                    push_decoded(esd_pkg::C_X);
                    push_decoded(hex_held);
                end
                default: ;
            endcase
            dec_phase = esd_pkg::PH_PLAIN;
            oct_acc   = '0;
            oct_cnt   = '0;
            hex_held  = '0;
        end
        for (int k = 0; k < step_bytes.size(); k++) begin
            expected_bytes.push_back('{data: step_bytes[k], run_end: k == step_bytes.size() - 1});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            strip_en  = 1'b1;
            dec_phase = esd_pkg::PH_PLAIN;
            oct_acc   = '0;
            oct_cnt   = '0;
            hex_held  = '0;
            expected_bytes.delete();
        end else begin
            if (i_cfg_wr_en) strip_en = i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready) decode_request(i_s_tdata, i_s_tuser, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                o_checked++;
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected output, expected none, got byte %02h tlast %0b",
                             $time, i_m_tdata, i_m_tlast);
                    o_mismatches++;
                end else begin
                    oldest = expected_bytes.pop_front();
                    if (i_m_tdata !== oldest.data) begin
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, oldest.data, i_m_tdata);
                        o_mismatches++;
                    end
                    if (i_m_tlast !== oldest.run_end) begin
                        $display("%0t: run_end expected %0b, got %0b (byte %02h)",
                                 $time, oldest.run_end, i_m_tlast, oldest.data);
                        o_mismatches++;
                    end
                end
            end
        end
        o_outstanding = expected_bytes.size();
    end

endmodule

[sim/escape_sequence_decoder_unit_tb.sv]
// Testbench top for escape_sequence_decoder_unit: drives string literal requests and
// output back-pressure. Depends on esd_pkg, the decoder RTL and the checker module.
module escape_sequence_decoder_unit_tb;

    localparam int MAX_CYCLES  = 200000;
    localparam int HOLD_CYCLES = 60;

    typedef enum {
        TK_PLAIN, TK_ANY_BYTE, TK_SIMPLE, TK_OCTAL, TK_HEX, TK_BAD_HEX, TK_UNKNOWN, TK_LONE_BSL
    } t_token;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_wr_en     = 1'b0;
    logic       i_cfg_wr_data   = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata  = 8'h00;
    logic       i_s_axis_tuser  = 1'b0;
    logic       i_s_axis_tlast  = 1'b0;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tlast;

    int mismatches;
    int outstanding;
    int checked;
    int requests_sent = 0;
    int literals_sent = 0;
    int cycle_cnt     = 0;
    int hold_left     = 0;
    int stall_left    = 0;
    bit tx_gaps_en    = 1'b1;
    bit rx_gaps_en    = 1'b1;
    bit hold_req      = 1'b0;
    bit strip_now     = 1'b1;

    logic [7:0] lit_q[$];

    always #10 i_clk = ~i_clk;

    escape_sequence_decoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    escape_sequence_decoder_unit_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_axis_tvalid),
        .i_s_tready    (o_s_axis_tready),
        .i_s_tdata     (i_s_axis_tdata),
        .i_s_tuser     (i_s_axis_tuser),
        .i_s_tlast     (i_s_axis_tlast),
        .i_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .i_m_tdata     (o_m_axis_tdata),
        .i_m_tlast     (o_m_axis_tlast),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return esd_pkg::C_ZERO + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    // Output side: random stalls, plus one long hold-off when the stimulus asks for it.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (rx_gaps_en && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 2);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == MAX_CYCLES) begin
            $display("Timeout after %0d cycles with %0d bytes still expected",
                     cycle_cnt, outstanding);
            $display("escape_sequence_decoder_unit_tb failed");
            $finish;
        end
    end

    // Leaves tvalid high on return so back-to-back requests need no extra edge.
    task automatic send_request(input logic [7:0] b, input logic first, input logic last);
        int gap;
        gap = tx_gaps_en ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= first;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic send_literal(input bit terminated);
        for (int i = 0; i < lit_q.size(); i++) begin
            send_request(lit_q[i], i == 0, terminated && (i == lit_q.size() - 1));
        end
        literals_sent++;
    endtask

    task automatic add_token();
        t_token     kind;
        int         r;
        logic [7:0] ch;
        r = $urandom_range(0, 99);
        kind = r < 30 ? TK_PLAIN : r < 40 ? TK_ANY_BYTE : r < 58 ? TK_SIMPLE :
               r < 70 ? TK_OCTAL : r < 82 ? TK_HEX : r < 89 ? TK_BAD_HEX :
               r < 95 ? TK_UNKNOWN : TK_LONE_BSL;
        case (kind)
            TK_PLAIN: begin
                ch = 8'($urandom_range(32, 126));
                if (ch == esd_pkg::C_BSL) ch = esd_pkg::C_X;
                lit_q.push_back(ch);
            end
            TK_ANY_BYTE: lit_q.push_back(8'($urandom_range(0, 255)));
            TK_SIMPLE: begin
                lit_q.push_back(esd_pkg::C_BSL);
                case ($urandom_range(0, 7))
                    0:       lit_q.push_back(esd_pkg::C_N);
                    1:       lit_q.push_back(esd_pkg::C_R);
                    2:       lit_q.push_back(esd_pkg::C_T);
                    3:       lit_q.push_back(esd_pkg::C_B);
                    4:       lit_q.push_back(esd_pkg::C_F);
                    5:       lit_q.push_back(esd_pkg::C_V);
                    6:       lit_q.push_back(esd_pkg::C_BSL);
                    default: lit_q.push_back(esd_pkg::C_QUOTE);
                endcase
            end
            TK_OCTAL: begin
                lit_q.push_back(esd_pkg::C_BSL);
                lit_q.push_back(esd_pkg::C_ZERO);
                repeat ($urandom_range(0, 2))
                    lit_q.push_back(esd_pkg::C_ZERO + 8'($urandom_range(0, 7)));
                // An 8 or 9 after fewer than two digits ends the escape early; after two it is plain.
                if ($urandom_range(0, 3) == 0)
                    lit_q.push_back(esd_pkg::C_ZERO + 8'($urandom_range(8, 9)));
            end
            TK_HEX: begin
                lit_q.push_back(esd_pkg::C_BSL);
                lit_q.push_back(esd_pkg::C_X);
                lit_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
                lit_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            end
            TK_BAD_HEX: begin
                lit_q.push_back(esd_pkg::C_BSL);
                lit_q.push_back(esd_pkg::C_X);
                if ($urandom_range(0, 1) == 1)
                    lit_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
                else
                    lit_q.push_back(8'($urandom_range(0, 255)));
                lit_q.push_back(8'($urandom_range(0, 255)));
            end
            TK_UNKNOWN: begin
                lit_q.push_back(esd_pkg::C_BSL);
                lit_q.push_back(8'($urandom_range(0, 255)));
            end
            default: lit_q.push_back(esd_pkg::C_BSL);
        endcase
    endtask

    task automatic build_literal();
        int n;
        lit_q.delete();
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16)
                                        : $urandom_range(strip_now ? 0 : 1, 5);
        // First and, if terminated, last bytes are dropped, so now and then they are random.
        if (strip_now)
            lit_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                        : esd_pkg::C_QUOTE);
        repeat (n) add_token();
        if (strip_now)
            lit_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                        : esd_pkg::C_QUOTE);
    endtask

    task automatic run_random(input int count);
        int stop;
        int r;
        stop = requests_sent + count;
        while (requests_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
            end else begin
                build_literal();
                send_literal(r >= 15);
            end
        end
    endtask

    // The extra edges cover a request still in flight that causes no bytes.
    task automatic drain_decoder();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_strip(input logic v);
        drain_decoder();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        strip_now = v;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One-byte literals keep their only byte even with quote stripping on.
        lit_q = '{8'hFF};
        send_literal(1'b1);
        lit_q = '{8'h00};
        send_literal(1'b1);
        // Octal cut short by a letter, a bad \x pair, and a trailing backslash at the end.
        lit_q = '{esd_pkg::C_QUOTE, esd_pkg::C_BSL, esd_pkg::C_ZERO, 8'h37, 8'h7A,
                  esd_pkg::C_BSL, esd_pkg::C_X, 8'h47, 8'h31, esd_pkg::C_BSL,
                  esd_pkg::C_QUOTE};
        send_literal(1'b1);
        // An unterminated \x escape is discarded by the next literal's first byte.
        lit_q = '{esd_pkg::C_QUOTE, esd_pkg::C_BSL, esd_pkg::C_X, 8'h34};
        send_literal(1'b0);
        // Three-digit octal, then a lone \0 flushed at the end.
        lit_q = '{esd_pkg::C_QUOTE, esd_pkg::C_BSL, esd_pkg::C_ZERO, 8'h37, 8'h37,
                  esd_pkg::C_BSL, esd_pkg::C_ZERO, esd_pkg::C_QUOTE};
        send_literal(1'b1);
        // \x with one held byte flushed at the end.
        lit_q = '{esd_pkg::C_QUOTE, esd_pkg::C_BSL, esd_pkg::C_X, 8'h41, esd_pkg::C_QUOTE};
        send_literal(1'b1);

        // Long output hold-off while requests keep coming, so the input backs up.
        drain_decoder();
        tx_gaps_en = 1'b0;
        hold_req = 1'b1;
        lit_q = '{esd_pkg::C_QUOTE};
        repeat (14) add_token();
        lit_q.push_back(esd_pkg::C_QUOTE);
        send_literal(1'b1);
        tx_gaps_en = 1'b1;

        run_random(40);
        write_strip(1'b0);
        run_random(45);
        write_strip(1'b1);
        tx_gaps_en = 1'b0;
        rx_gaps_en = 1'b0;
        run_random(35);
        tx_gaps_en = 1'b1;
        rx_gaps_en = 1'b1;
        write_strip(1'b0);
        run_random(40);

        drain_decoder();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d requests in %0d literals, strip_quotes 1/0/1/0, with and without idling",
                 requests_sent, literals_sent);
        $display("Checked %0d decoded bytes, %0d mismatches", checked, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("escape_sequence_decoder_unit_tb passed");
        end else begin
            $display("escape_sequence_decoder_unit_tb failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/esd_pkg.sv
hdl/esd_core.sv
hdl/esd_outbuf.sv
hdl/escape_sequence_decoder_unit.sv
sim/escape_sequence_decoder_unit_checker.sv
sim/escape_sequence_decoder_unit_tb.sv
